@@ sv/pli_pkg.sv @@
package pli_pkg;

  localparam int COORD_W        = 16;
  localparam int POINT_W        = 2 * COORD_W;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = 2 * DIFF_W;
  localparam int QUO_W          = 2 * COORD_W;
  localparam int DEN_W          = COORD_W;
  localparam int VALUE_W        = 36;
  localparam int SEG_W          = 4;
  localparam int IDX_W          = 4;
  localparam int PIU_W          = 5;
  localparam int APB_AW         = 3;
  localparam int APB_DW         = 32;
  localparam int MAX_POINTS_DEF = 16;

  localparam logic [PIU_W-1:0] PIU_RESET = 5'd2;
  localparam logic [PIU_W-1:0] PIU_MIN   = 5'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic REG_POINTS_IN_USE = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RD_LO,
    ST_RD_HI,
    ST_DIFF,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_e;

endpackage

@@ sv/pli_mem.sv @@
module pli_mem #(
  parameter int DEPTH = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [pli_pkg::POINT_W-1:0]  wr_data_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  output logic [pli_pkg::POINT_W-1:0]  rd_data_o
);

  logic [pli_pkg::POINT_W-1:0] mem [DEPTH];
  logic [pli_pkg::POINT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/pli_div.sv @@
module pli_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pli_pkg::QUO_W-1:0]  num_i,
  input  logic [pli_pkg::DEN_W-1:0]  den_i,
  output logic                       done_o,
  output logic [pli_pkg::QUO_W-1:0]  quo_o
);

  localparam int QW = pli_pkg::QUO_W;
  localparam int DW = pli_pkg::DEN_W;
  localparam int CW = $clog2(QW + 1);

  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [QW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;

  assign rem_sh = {rem_q, quo_q[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (!diff[DW+1]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DW-1:0];
        quo_q <= {quo_q[QW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ sv/piecewise_linear_interpolator.sv @@
// Piecewise linear interpolator. A load transaction (mode 0) writes one breakpoint and leaves the
// sequencer idle; a query transaction (mode 1) walks the breakpoint memory one entry per cycle
// until it finds the segment, reads both ends, forms the product and then runs a restoring
// divider one quotient bit per cycle, or skips the divider when the segment ends are equal.
// busy_o is high throughout. Each result is shown for one cycle with done_o high; the receiver
// cannot stall, so it must take every result in that cycle. Breakpoints must be loaded before
// a query reads them. points_in_use is to be written over the APB port only while idle; the
// block itself does not enforce it.
module piecewise_linear_interpolator #(
  parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               mode_i,
  input  logic [pli_pkg::IDX_W-1:0]          point_index_i,
  input  logic signed [pli_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [pli_pkg::COORD_W-1:0] point_y_i,
  input  logic signed [pli_pkg::COORD_W-1:0] query_x_i,
  output logic                               done_o,
  output logic signed [pli_pkg::VALUE_W-1:0] value_o,
  output logic [pli_pkg::SEG_W-1:0]          segment_low_o,
  output logic                               div_error_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pli_pkg::APB_AW-1:0]         paddr,
  input  logic [pli_pkg::APB_DW-1:0]         pwdata,
  output logic [pli_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = pli_pkg::COORD_W;
  localparam int FW = pli_pkg::DIFF_W;
  localparam int PW = pli_pkg::PROD_W;
  localparam int QW = pli_pkg::QUO_W;
  localparam int VW = pli_pkg::VALUE_W;

  pli_pkg::state_e state_q, state_d;

  logic [pli_pkg::PIU_W-1:0] piu_q;
  logic                      accept;
  logic                      load_en;
  logic [8:0]                n_used;
  logic [AW-1:0]             last;
  logic [AW-1:0]             last_q;
  logic [AW-1:0]             k_q;
  logic [AW-1:0]             lo_q;
  logic [AW-1:0]             k_fin;
  logic [AW-1:0]             rd_addr;
  logic [pli_pkg::POINT_W-1:0] rd_data;
  logic signed [CW-1:0]      rd_x;
  logic signed [CW-1:0]      rd_y;
  logic                      cont;
  logic signed [CW-1:0]      q_q;
  logic signed [CW-1:0]      xl_q;
  logic signed [CW-1:0]      yl_q;
  logic signed [FW-1:0]      dx_q;
  logic signed [FW-1:0]      dy_q;
  logic signed [FW-1:0]      dq_q;
  logic signed [PW-1:0]      prod_q;
  logic                      neg_q;
  logic                      err_q;
  logic [PW-1:0]             prod_mag;
  logic [FW-1:0]             dx_mag;
  logic                      div_start;
  logic                      div_done;
  logic [QW-1:0]             quo;
  logic signed [VW-1:0]      yl_ext;
  logic signed [VW-1:0]      quo_ext;
  logic signed [VW-1:0]      value_d;
  logic                      done_q;
  logic signed [VW-1:0]      value_q;
  logic [pli_pkg::SEG_W-1:0] seg_q;
  logic                      err_out_q;

  // apb register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piu_q <= pli_pkg::PIU_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == pli_pkg::REG_POINTS_IN_USE)) begin
      piu_q <= pwdata[pli_pkg::PIU_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == pli_pkg::REG_POINTS_IN_USE) begin
      prdata = pli_pkg::APB_DW'(piu_q);
    end
  end

  // transaction accept and breakpoint load
  assign busy_o  = (state_q != pli_pkg::ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign load_en = accept && (mode_i == pli_pkg::MODE_LOAD) &&
                   (32'(point_index_i) < MAX_POINTS);

  always_comb begin
    if (piu_q < pli_pkg::PIU_MIN) begin
      n_used = 9'(pli_pkg::PIU_MIN);
    end else if (32'(piu_q) > MAX_POINTS) begin
      n_used = 9'(MAX_POINTS);
    end else begin
      n_used = 9'(piu_q);
    end
  end

  assign last = AW'(n_used - 9'd1);

  pli_mem #(
    .DEPTH (MAX_POINTS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (AW'(point_index_i)),
    .wr_data_i ({point_x_i, point_y_i}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_x  = rd_data[pli_pkg::POINT_W-1:CW];
  assign rd_y  = rd_data[CW-1:0];
  assign cont  = (k_q != last_q) && (q_q > rd_x);
  assign k_fin = (k_q == '0) ? AW'(1) : k_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      pli_pkg::ST_IDLE: begin
        if (accept && (mode_i == pli_pkg::MODE_QUERY)) begin
          state_d = pli_pkg::ST_SEARCH;
        end
      end
      pli_pkg::ST_SEARCH: begin
        if (!cont) begin
          state_d = pli_pkg::ST_RD_LO;
        end
      end
      pli_pkg::ST_RD_LO:  state_d = pli_pkg::ST_RD_HI;
      pli_pkg::ST_RD_HI:  state_d = pli_pkg::ST_DIFF;
      pli_pkg::ST_DIFF:   state_d = pli_pkg::ST_MUL;
      pli_pkg::ST_MUL: begin
        if (dx_q == '0) begin
          state_d = pli_pkg::ST_FINISH;
        end else begin
          state_d = pli_pkg::ST_DIV_GO;
        end
      end
      pli_pkg::ST_DIV_GO: state_d = pli_pkg::ST_DIV_WAIT;
      pli_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_d = pli_pkg::ST_FINISH;
        end
      end
      pli_pkg::ST_FINISH: state_d = pli_pkg::ST_IDLE;
      default:            state_d = pli_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = '0;
    div_start = 1'b0;
    case (state_q)
      pli_pkg::ST_SEARCH: rd_addr = k_q + AW'(1);
      pli_pkg::ST_RD_LO:  rd_addr = lo_q;
      pli_pkg::ST_RD_HI:  rd_addr = k_q;
      pli_pkg::ST_DIV_GO: div_start = 1'b1;
      default: begin
        rd_addr   = '0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pli_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == pli_pkg::ST_FINISH);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      pli_pkg::ST_IDLE: begin
        q_q    <= query_x_i;
        last_q <= last;
        k_q    <= '0;
      end
      pli_pkg::ST_SEARCH: begin
        if (cont) begin
          k_q <= k_q + AW'(1);
        end else begin
          k_q  <= k_fin;
          lo_q <= k_fin - AW'(1);
        end
      end
      default: begin
      end
    endcase
    if (state_q == pli_pkg::ST_RD_HI) begin
      xl_q <= rd_x;
      yl_q <= rd_y;
    end
    if (state_q == pli_pkg::ST_DIFF) begin
      dx_q <= FW'(rd_x) - FW'(xl_q);
      dy_q <= FW'(rd_y) - FW'(yl_q);
      dq_q <= FW'(q_q) - FW'(xl_q);
    end
    if (state_q == pli_pkg::ST_MUL) begin
      prod_q <= dy_q * dq_q;
      err_q  <= (dx_q == '0);
    end
    if (state_q == pli_pkg::ST_DIV_GO) begin
      neg_q <= prod_q[PW-1] ^ dx_q[FW-1];
    end
  end

  assign prod_mag = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
  assign dx_mag   = dx_q[FW-1] ? FW'(-dx_q) : FW'(dx_q);

  pli_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_mag[QW-1:0]),
    .den_i   (dx_mag[pli_pkg::DEN_W-1:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign yl_ext  = VW'(yl_q);
  assign quo_ext = $signed({{(VW-QW){1'b0}}, quo});

  always_comb begin
    if (err_q) begin
      value_d = yl_ext;
    end else if (neg_q) begin
      value_d = yl_ext - quo_ext;
    end else begin
      value_d = yl_ext + quo_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == pli_pkg::ST_FINISH) begin
      value_q   <= value_d;
      seg_q     <= pli_pkg::SEG_W'(lo_q);
      err_out_q <= err_q;
    end
  end

  assign done_o        = done_q;
  assign value_o       = value_q;
  assign segment_low_o = seg_q;
  assign div_error_o   = err_out_q;

endmodule

@@ test/piecewise_linear_interpolator_tb.sv @@
`timescale 1ns / 100ps

module piecewise_linear_interpolator_tb;

  localparam int COORD_W = pli_pkg::COORD_W;
  localparam int VALUE_W = pli_pkg::VALUE_W;
  localparam int SEG_W   = pli_pkg::SEG_W;
  localparam int IDX_W   = pli_pkg::IDX_W;
  localparam int PIU_W   = pli_pkg::PIU_W;
  localparam int APB_AW  = pli_pkg::APB_AW;
  localparam int APB_DW  = pli_pkg::APB_DW;
  localparam int SLOTS = pli_pkg::MAX_POINTS_DEF;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int SETTLE_CYCLES = 64;
  localparam logic [APB_AW-1:0] PIU_ADDR = {pli_pkg::REG_POINTS_IN_USE, 2'b00};
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = 3'd4;
  localparam logic signed [COORD_W-1:0] X_MIN = 16'h8000;
  localparam logic signed [COORD_W-1:0] X_MAX = 16'h7fff;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [SEG_W-1:0] seg;
    logic err;
  } reading_t;

  typedef struct packed {
    logic mode;
    logic [IDX_W-1:0] slot;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] qx;
    logic known;
    logic signed [VALUE_W-1:0] value;
    logic [SEG_W-1:0] seg;
    logic err;
  } step_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic mode_i = pli_pkg::MODE_LOAD;
  logic [IDX_W-1:0] point_index_i = '0;
  logic signed [COORD_W-1:0] point_x_i = '0;
  logic signed [COORD_W-1:0] point_y_i = '0;
  logic signed [COORD_W-1:0] query_x_i = '0;
  logic done_o;
  logic signed [VALUE_W-1:0] value_o;
  logic [SEG_W-1:0] segment_low_o;
  logic div_error_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic pready;

  logic signed [COORD_W-1:0] bp_x [SLOTS];
  logic signed [COORD_W-1:0] bp_y [SLOTS];
  logic [PIU_W-1:0] points_in_use_reg = pli_pkg::PIU_RESET;
  reading_t pending_readings [$];
  reading_t oldest;
  int mismatches = 0;
  int burst_left = 0;
  int gap_max = 8;

  step_t directed_steps [24] = '{
    '{pli_pkg::MODE_LOAD,  4'd0, 16'sd0,   16'sd0,   16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_LOAD,  4'd1, 16'sd256, 16'sd512, 16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd128, 1'b1, 36'sd256,    4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MIN,    1'b1, -36'sd65536, 4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MAX,    1'b1, 36'sd65534,  4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd256, 1'b1, 36'sd512,    4'd0, 1'b0},
    // truncation toward zero on both sides of the lower breakpoint
    '{pli_pkg::MODE_LOAD,  4'd1, 16'sd3,   -16'sd1,  16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   -16'sd2,  1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd2,   1'b0, 36'sd0,      4'd0, 1'b0},
    // equal segment ends
    '{pli_pkg::MODE_LOAD,  4'd1, 16'sd0,   16'sd100, 16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd5,   1'b1, 36'sd0,      4'd0, 1'b1},
    '{pli_pkg::MODE_LOAD,  4'd0, X_MIN,    X_MIN,    16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_LOAD,  4'd1, X_MAX,    X_MAX,    16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MIN,    1'b1, -36'sd32768, 4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MAX,    1'b1, 36'sd32767,  4'd0, 1'b0},
    // steepest slope, largest magnitudes
    '{pli_pkg::MODE_LOAD,  4'd1, -16'sd32767, X_MAX, 16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MAX,    1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_LOAD,  4'd0, X_MIN,    X_MAX,    16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_LOAD,  4'd1, -16'sd32767, X_MIN, 16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   X_MAX,    1'b0, 36'sd0,      4'd0, 1'b0},
    // descending breakpoints
    '{pli_pkg::MODE_LOAD,  4'd0, 16'sd256, 16'sd0,   16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_LOAD,  4'd1, -16'sd256, 16'sd256, 16'sd0,  1'b0, 36'sd0,      4'd0, 1'b0},
    '{pli_pkg::MODE_QUERY, 4'd0, 16'sd0,   16'sd0,   16'sd0,   1'b0, 36'sd0,      4'd0, 1'b0}
  };

  piecewise_linear_interpolator DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start_i(start_i),
    .busy_o(busy_o),
    .mode_i(mode_i),
    .point_index_i(point_index_i),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .query_x_i(query_x_i),
    .done_o(done_o),
    .value_o(value_o),
    .segment_low_o(segment_low_o),
    .div_error_o(div_error_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

  function automatic reading_t interpolate(input logic signed [COORD_W-1:0] q);
    int n;
    int k;
    longint xl, xh, yl, yh, dx, v;
    reading_t r;
    n = int'(points_in_use_reg);
    if (n < 2) n = 2;
    if (n > SLOTS) n = SLOTS;
    k = 0;
    while (k < n - 1 && q > bp_x[k]) k++;
    if (k == 0) k = 1;
    xl = bp_x[k-1];
    xh = bp_x[k];
    yl = bp_y[k-1];
    yh = bp_y[k];
    dx = xh - xl;
    if (dx == 0) begin
      v = yl;
      r.err = 1'b1;
    end else begin
      v = yl + ((yh - yl) * (longint'(q) - xl)) / dx;
      r.err = 1'b0;
    end
    r.value = v[VALUE_W-1:0];
    r.seg = SEG_W'(k - 1);
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp16(input int v);
    if (v > 32767) return X_MAX;
    if (v < -32768) return X_MIN;
    return COORD_W'(v);
  endfunction

  task automatic pace();
    int gap;
    if (gap_max == 0) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = int'($urandom_range(0, 24));
      gap = int'($urandom_range(1, gap_max));
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic issue(input logic m, input logic [IDX_W-1:0] slot,
                       input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
                       input logic signed [COORD_W-1:0] qx, input logic known,
                       input reading_t want);
    start_i <= 1'b1;
    mode_i <= m;
    point_index_i <= slot;
    point_x_i <= px;
    point_y_i <= py;
    query_x_i <= qx;
    do @(posedge clk_i); while (busy_o);
    if (m == pli_pkg::MODE_LOAD) begin
      bp_x[slot] = px;
      bp_y[slot] = py;
    end else begin
      pending_readings.push_back(known ? want : interpolate(qx));
    end
    pace();
  endtask

  // ascending breakpoints in every slot, with the odd repeated abscissa
  task automatic refill_table();
    logic signed [COORD_W-1:0] xs [SLOTS];
    logic signed [COORD_W-1:0] ys [SLOTS];
    int span;
    int x;
    int y;
    int i;
    bit smooth;
    bit down;
    span = int'($urandom_range(1, 4095));
    x = -32768 + int'($urandom_range(0, 65535 - 15 * span));
    y = int'($urandom_range(0, 65535)) - 32768;
    smooth = 1'($urandom_range(0, 1));
    down = 1'($urandom_range(0, 1));
    for (i = 0; i < SLOTS; i++) begin
      if (i > 0) begin
        if ($urandom_range(0, 9) != 0) x += int'($urandom_range(1, span));
        if (smooth) y += int'($urandom_range(0, 1024)) - 512;
        else y = int'($urandom_range(0, 65535)) - 32768;
      end
      xs[i] = COORD_W'(x);
      ys[i] = clamp16(y);
    end
    for (i = 0; i < SLOTS; i++) begin
      if (down)
        issue(pli_pkg::MODE_LOAD, IDX_W'(SLOTS - 1 - i), xs[SLOTS-1-i], ys[SLOTS-1-i],
              16'($urandom()), 1'b0, '0);
      else
        issue(pli_pkg::MODE_LOAD, IDX_W'(i), xs[i], ys[i], 16'($urandom()), 1'b0, '0);
    end
  endtask

  task automatic settle();
    start_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == PIU_ADDR) points_in_use_reg = data[PIU_W-1:0];
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_readings.size() == 0) begin
        $error("value: no transaction expected, got %0d", value_o);
        mismatches++;
      end else begin
        oldest = pending_readings.pop_front();
        if (value_o !== oldest.value) begin
          $error("value: expected %0d, got %0d", oldest.value, value_o);
          mismatches++;
        end
        if (segment_low_o !== oldest.seg) begin
          $error("segment_low: expected %0d, got %0d", oldest.seg, segment_low_o);
          mismatches++;
        end
        if (div_error_o !== oldest.err) begin
          $error("div_error: expected %0d, got %0d", oldest.err, div_error_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int plan [PHASES] = '{16, 2, 0, 9, 31, 1, 17, 0, 16};
    int phase;
    int item;
    int roll;
    int s;
    logic [APB_DW-1:0] data;
    logic signed [COORD_W-1:0] q;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i])
      issue(directed_steps[i].mode, directed_steps[i].slot, directed_steps[i].px,
            directed_steps[i].py, directed_steps[i].qx, directed_steps[i].known,
            reading_t'{directed_steps[i].value, directed_steps[i].seg, directed_steps[i].err});

    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      data = $urandom();
      data[PIU_W-1:0] = (phase == 7) ? PIU_W'($urandom_range(2, SLOTS)) : PIU_W'(plan[phase]);
      write_register(PIU_ADDR, data);
      if (phase == 3) write_register(UNMAPPED_ADDR, $urandom());
      gap_max = (phase % 3 == 1) ? 0 : ((phase % 3 == 0) ? 6 : 60);
      burst_left = 0;
      refill_table();
      for (item = 0; item < ITEMS_PER_PHASE; item++) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 2) begin
          refill_table();
        end else if (roll < 20) begin
          issue(pli_pkg::MODE_LOAD, IDX_W'($urandom_range(0, SLOTS - 1)), 16'($urandom()),
                16'($urandom()), 16'($urandom()), 1'b0, '0);
        end else begin
          s = int'($urandom_range(0, SLOTS - 1));
          case ($urandom_range(0, 4))
            0, 1: q = 16'($urandom());
            2, 3: q = clamp16(int'(bp_x[s]) + int'($urandom_range(0, 8)) - 4);
            default: q = bp_x[s];
          endcase
          issue(pli_pkg::MODE_QUERY, IDX_W'($urandom_range(0, SLOTS - 1)), 16'($urandom()),
                16'($urandom()), q, 1'b0, '0);
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
